// ----- sv/barometric_pressure_to_altitude_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef BAROMETRIC_PRESSURE_TO_ALTITUDE_UNIT_DEFINES_SVH
`define BAROMETRIC_PRESSURE_TO_ALTITUDE_UNIT_DEFINES_SVH

// cons must hold in the same cycle as ante
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// when cons holds, $past((ante), depth) must be true
`define BPA_ASSERT_PAST(label, cons, ante, depth, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cons) |-> $past((ante), depth)) else $error(msg);

`endif

// ----- sv/bpa_pkg.sv -----
// types and constants of the barometric altitude unit
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int P_W      = 18;
    localparam int CFG_W    = 17;
    localparam int TEMP_W   = 11;
    localparam int ALT_W    = 21;
    localparam int K_W      = 23;
    localparam int M_W      = 28;
    localparam int Q_W      = 24;
    localparam int A_W      = 26;
    localparam int IDX_W    = 2;

    localparam int TAYLOR_TERMS = 47;

    localparam logic [31:0] LN2_HI = 32'hB17217F7;
    localparam logic [31:0] LN2_LO = 32'hD1CF79AC;

    // floor(2^32 / 13) + 1, exact for dividends below 2^28
    localparam int          R13_W  = 29;
    localparam logic [R13_W-1:0] R13 = 29'd330382100;
    localparam int          R13_SH = 32;

    localparam int TEMP_BASE = 2730;
    localparam int K_SCALE   = 2000;

    localparam int ALT_MAX = 1000000;
    localparam int ALT_MIN = -500000;

    localparam logic [CFG_W-1:0]  REF_ALT_RST  = 17'd0;
    localparam logic [CFG_W-1:0]  REF_PRES_RST = 17'd101300;
    localparam logic [TEMP_W-1:0] REF_TEMP_RST = 11'd150;

    localparam logic [IDX_W-1:0] REG_REF_ALT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_REF_PRES = 2'd1;
    localparam logic [IDX_W-1:0] REG_REF_TEMP = 2'd2;

    typedef struct packed {
        logic valid;
        logic zero;
    } bpa_tag_t;

endpackage

// ----- sv/bpa_div_cell.sv -----
// one restoring division step: one quotient bit per cell
`timescale 1ns / 1ps

module bpa_div_cell #(
    parameter int NUM_W = 46
) (
    input  logic                        clk,
    input  logic [bpa_pkg::CFG_W-1:0]   divisor,
    input  logic [bpa_pkg::CFG_W-1:0]   rem_in,
    input  logic [NUM_W-1:0]            num_in,
    output logic [bpa_pkg::CFG_W-1:0]   rem_out,
    output logic [NUM_W-1:0]            num_out
);

    localparam int RW = bpa_pkg::CFG_W;

    logic [RW:0]     rem_wide;
    logic [RW:0]     diff;
    logic            take;
    logic [RW-1:0]   rem_next;
    logic [NUM_W-1:0] num_next;
    logic [RW-1:0]   rem_reg;
    logic [NUM_W-1:0] num_reg;

    assign rem_wide = {rem_in, num_in[NUM_W-1]};
    assign diff     = rem_wide - {1'b0, divisor};
    assign take     = rem_wide >= {1'b0, divisor};
    assign rem_next = take ? diff[RW-1:0] : rem_wide[RW-1:0];
    assign num_next = {num_in[NUM_W-2:0], take};

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;

endmodule

// ----- sv/bpa_log_cell.sv -----
// one log2 fraction bit by squaring the mantissa
`timescale 1ns / 1ps

module bpa_log_cell #(
    parameter int FRAC_BITS = 28,
    parameter int TAG_W     = 7
) (
    input  logic                   clk,
    input  logic [FRAC_BITS+1:0]   x_in,
    input  logic [FRAC_BITS-1:0]   frac_in,
    input  logic [TAG_W-1:0]       tag_in,
    output logic [FRAC_BITS+1:0]   x_out,
    output logic [FRAC_BITS-1:0]   frac_out,
    output logic [TAG_W-1:0]       tag_out
);

    localparam int XW = FRAC_BITS + 2;
    localparam int SW = 2 * XW;

    logic [SW-1:0]        sq;
    logic [XW-1:0]        sq_q;
    logic                 bit_one;
    logic [XW-1:0]        x_next;
    logic [FRAC_BITS-1:0] frac_next;
    logic [XW-1:0]        x_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [TAG_W-1:0]     tag_reg;

    assign sq        = SW'(x_in) * SW'(x_in);
    assign sq_q      = sq[FRAC_BITS +: XW];
    assign bit_one   = sq_q[FRAC_BITS+1];
    assign x_next    = bit_one ? {1'b0, sq_q[XW-1:1]} : sq_q;
    assign frac_next = {frac_in[FRAC_BITS-2:0], bit_one};

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        frac_reg <= frac_next;
        tag_reg  <= tag_in;
    end

    assign x_out    = x_reg;
    assign frac_out = frac_reg;
    assign tag_out  = tag_reg;

endmodule

// ----- sv/bpa_exp_cell.sv -----
// one taylor term of e^t: term * t, then exact divide by the term index
`timescale 1ns / 1ps

module bpa_exp_cell #(
    parameter int FRAC_BITS = 28,
    parameter int TERM_K    = 1,
    parameter int TAG_W     = 7
) (
    input  logic                   clk,
    input  logic [FRAC_BITS:0]     term_in,
    input  logic [FRAC_BITS-1:0]   t_in,
    input  logic [FRAC_BITS+1:0]   sum_in,
    input  logic [TAG_W-1:0]       tag_in,
    output logic [FRAC_BITS:0]     term_out,
    output logic [FRAC_BITS-1:0]   t_out,
    output logic [FRAC_BITS+1:0]   sum_out,
    output logic [TAG_W-1:0]       tag_out
);

    localparam int CK  = $clog2(TERM_K);
    localparam int SH  = FRAC_BITS + CK;
    localparam int MW  = FRAC_BITS + 2;
    localparam int PAW = 2 * FRAC_BITS + 1;
    localparam int PBW = 2 * FRAC_BITS + CK + 2;
    localparam int SUW = FRAC_BITS + 2;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << SH) / TERM_K + 64'd1;
    localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];

    logic [PAW-1:0]       prod_a;
    logic [FRAC_BITS-1:0] x_next;
    logic [FRAC_BITS-1:0] x_reg;
    logic [FRAC_BITS-1:0] t_a_reg;
    logic [SUW-1:0]       sum_a_reg;
    logic [TAG_W-1:0]     tag_a_reg;

    logic [PBW-1:0]       prod_b;
    logic [FRAC_BITS-1:0] q;
    logic [FRAC_BITS:0]   term_next;
    logic [SUW-1:0]       sum_next;
    logic [FRAC_BITS:0]   term_reg;
    logic [FRAC_BITS-1:0] t_b_reg;
    logic [SUW-1:0]       sum_b_reg;
    logic [TAG_W-1:0]     tag_b_reg;

    assign prod_a = PAW'(term_in) * PAW'(t_in);
    assign x_next = prod_a[FRAC_BITS +: FRAC_BITS];

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        t_a_reg   <= t_in;
        sum_a_reg <= sum_in;
        tag_a_reg <= tag_in;
    end

    assign prod_b    = PBW'(x_reg) * PBW'(RECIP);
    assign q         = prod_b[SH +: FRAC_BITS];
    assign term_next = {1'b0, q};
    assign sum_next  = sum_a_reg + SUW'(q);

    always_ff @(posedge clk)
    begin
        term_reg  <= term_next;
        t_b_reg   <= t_a_reg;
        sum_b_reg <= sum_next;
        tag_b_reg <= tag_a_reg;
    end

    assign term_out = term_reg;
    assign t_out    = t_b_reg;
    assign sum_out  = sum_b_reg;
    assign tag_out  = tag_b_reg;

endmodule

// ----- sv/barometric_pressure_to_altitude_unit.sv -----
// top level: pressure to altitude pipeline built from cell chains
// throughput one request per cycle, busy stays low; the receiver cannot stall
// the chains set the latency: one quotient bit per divider cell,
// one log2 bit per squaring cell, two stages per taylor term cell
// reset clears the valid pipeline and loads the reference registers; no clearing pass
`timescale 1ns / 1ps

module barometric_pressure_to_altitude_unit #(
    parameter int FRAC_BITS = 28
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [bpa_pkg::P_W-1:0]          pressure_centi_mbar,
    output logic                             done,
    output logic signed [bpa_pkg::ALT_W-1:0] altitude_dm,
    output logic                             saturated,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpa_pkg::IDX_W-1:0]        cfg_index,
    input  logic [bpa_pkg::CFG_W-1:0]        cfg_data
);

    localparam int F      = FRAC_BITS;
    localparam int NW     = F + bpa_pkg::P_W;
    localparam int NS     = $clog2(NW);
    localparam int IW     = NS + 1;
    localparam int LW     = IW + F;
    localparam int NT     = bpa_pkg::TAYLOR_TERMS;
    localparam int PWW    = F + 5;
    localparam int RW     = bpa_pkg::CFG_W;
    localparam int K_W    = bpa_pkg::K_W;
    localparam int M_W    = bpa_pkg::M_W;
    localparam int Q_W    = bpa_pkg::Q_W;
    localparam int A_W    = bpa_pkg::A_W;
    localparam int ALT_W  = bpa_pkg::ALT_W;
    localparam int CPW    = LW + F;
    localparam int TPW    = F + 32;
    localparam int KPW    = PWW + K_W;
    localparam int QPW    = M_W + bpa_pkg::R13_W;

    localparam int TB_COL  = NW + NS + F + 5;
    localparam int EXP_END = TB_COL + 2 * NT;
    localparam int OUT_COL = EXP_END + 6;

    localparam logic [63:0]          C19_FULL = ((64'd19 << F) + 64'd50) / 64'd100;
    localparam logic [F-1:0]         C19      = C19_FULL[F-1:0];
    localparam logic [PWW-1:0]       ONE_Q    = {4'b0, 1'b1, {F{1'b0}}};
    localparam logic [F-1:0]         FMASK    = {F{1'b1}};
    localparam logic signed [A_W-1:0] A_HI    = A_W'(bpa_pkg::ALT_MAX);
    localparam logic signed [A_W-1:0] A_LO    = A_W'(bpa_pkg::ALT_MIN);

    // reference registers
    logic [RW-1:0]                   ref_alt_reg;
    logic [RW-1:0]                   ref_pres_reg;
    logic [bpa_pkg::TEMP_W-1:0]      ref_temp_reg;
    logic [11:0]                     tref_base;
    logic [K_W-1:0]                  k_next;
    logic [K_W-1:0]                  k_reg;
    logic [RW-1:0]                   pref_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_alt_reg  <= bpa_pkg::REF_ALT_RST;
            ref_pres_reg <= bpa_pkg::REF_PRES_RST;
            ref_temp_reg <= bpa_pkg::REF_TEMP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bpa_pkg::REG_REF_ALT:  ref_alt_reg  <= cfg_data;
                bpa_pkg::REG_REF_PRES: ref_pres_reg <= cfg_data;
                bpa_pkg::REG_REF_TEMP: ref_temp_reg <= cfg_data[bpa_pkg::TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign pref_eff  = (ref_pres_reg == '0) ? RW'(1) : ref_pres_reg;
    assign tref_base = 12'(bpa_pkg::TEMP_BASE) + {ref_temp_reg[bpa_pkg::TEMP_W-1], ref_temp_reg};
    assign k_next    = K_W'(tref_base) * K_W'(bpa_pkg::K_SCALE);

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
    end

    // valid and zero-pressure flags alongside the data
    bpa_pkg::bpa_tag_t sb_next;
    bpa_pkg::bpa_tag_t sb_reg [OUT_COL+1];

    assign sb_next.valid = start && !busy;
    assign sb_next.zero  = (pressure_centi_mbar == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= OUT_COL; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else
        begin
            sb_reg[0] <= sb_next;
            for (int i = 1; i <= OUT_COL; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    logic [bpa_pkg::P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= pressure_centi_mbar;
    end

    // ratio p * 2^F / pref
    logic [RW-1:0] rem_w [NW+1];
    logic [NW-1:0] num_w [NW+1];

    assign rem_w[0] = '0;
    assign num_w[0] = {p_reg, {F{1'b0}}};

    for (genvar i = 0; i < NW; i++)
    begin : g_div
        bpa_div_cell #(
            .NUM_W (NW)
        ) u_div_cell (
            .clk     (clk),
            .divisor (pref_eff),
            .rem_in  (rem_w[i]),
            .num_in  (num_w[i]),
            .rem_out (rem_w[i+1]),
            .num_out (num_w[i+1])
        );
    end

    // leading-one normalization
    logic [NW-1:0] nrm_w [NS+1];
    logic [NS-1:0] lz_w  [NS+1];

    assign nrm_w[0] = num_w[NW];
    assign lz_w[0]  = '0;

    for (genvar j = 0; j < NS; j++)
    begin : g_nrm
        localparam int SH = 1 << (NS - 1 - j);
        logic [NW-1:0] nrm_next;
        logic [NS-1:0] lz_next;
        logic [NW-1:0] nrm_reg;
        logic [NS-1:0] lz_reg;

        always_comb
        begin
            if (nrm_w[j][NW-1 -: SH] == '0)
            begin
                nrm_next = nrm_w[j] << SH;
                lz_next  = lz_w[j] + NS'(SH);
            end
            else
            begin
                nrm_next = nrm_w[j];
                lz_next  = lz_w[j];
            end
        end

        always_ff @(posedge clk)
        begin
            nrm_reg <= nrm_next;
            lz_reg  <= lz_next;
        end

        assign nrm_w[j+1] = nrm_reg;
        assign lz_w[j+1]  = lz_reg;
    end

    // log2 fraction by repeated squaring
    logic [F+1:0]  lx_w [F+1];
    logic [F-1:0]  lf_w [F+1];
    logic [IW-1:0] lt_w [F+1];

    assign lx_w[0] = {1'b0, nrm_w[NS][NW-1 -: F+1]};
    assign lf_w[0] = '0;
    assign lt_w[0] = IW'(bpa_pkg::P_W - 1) - {1'b0, lz_w[NS]};

    for (genvar i = 0; i < F; i++)
    begin : g_log
        bpa_log_cell #(
            .FRAC_BITS (F),
            .TAG_W     (IW)
        ) u_log_cell (
            .clk      (clk),
            .x_in     (lx_w[i]),
            .frac_in  (lf_w[i]),
            .tag_in   (lt_w[i]),
            .x_out    (lx_w[i+1]),
            .frac_out (lf_w[i+1]),
            .tag_out  (lt_w[i+1])
        );
    end

    // y = 0.19 * log2, truncated toward zero, then split into n and f
    logic [LW-1:0]  log_val;
    logic           neg_next;
    logic [LW-1:0]  mag_next;
    logic           neg_reg;
    logic [LW-1:0]  mag_reg;
    logic [CPW-1:0] c19_prod;
    logic [LW-1:0]  pr_next;
    logic           neg2_reg;
    logic [LW-1:0]  pr_reg;
    logic [LW:0]    pr_up;
    logic [IW-1:0]  n_next;
    logic [F-1:0]   f_next;
    logic [IW-1:0]  n_reg;
    logic [F-1:0]   f_reg;

    assign log_val  = {lt_w[F], lf_w[F]};
    assign neg_next = log_val[LW-1];
    assign mag_next = neg_next ? (~log_val + LW'(1)) : log_val;
    assign c19_prod = CPW'(mag_reg) * CPW'(C19);
    assign pr_next  = c19_prod[F +: LW];
    assign pr_up    = {1'b0, pr_reg} + (LW+1)'(FMASK);

    always_comb
    begin
        if (neg2_reg)
        begin
            n_next = ~pr_up[F +: IW] + IW'(1);
            f_next = ~pr_reg[F-1:0] + F'(1);
        end
        else
        begin
            n_next = pr_reg[F +: IW];
            f_next = pr_reg[F-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        neg2_reg <= neg_reg;
        pr_reg   <= pr_next;
        n_reg    <= n_next;
        f_reg    <= f_next;
    end

    // t = f * ln2, in two partial products
    logic [TPW-1:0] ta_next;
    logic [TPW-1:0] tb_next;
    logic [TPW-1:0] ta_reg;
    logic [TPW-1:0] tb_reg;
    logic [IW-1:0]  n_a_reg;
    logic [TPW:0]   t_sum;
    logic [F-1:0]   t_next;
    logic [F-1:0]   t_reg;
    logic [IW-1:0]  n_b_reg;

    assign ta_next = TPW'(f_reg) * TPW'(bpa_pkg::LN2_HI);
    assign tb_next = TPW'(f_reg) * TPW'(bpa_pkg::LN2_LO);
    assign t_sum   = {1'b0, ta_reg} + (TPW+1)'(tb_reg[TPW-1:32]);
    assign t_next  = t_sum[32 +: F];

    always_ff @(posedge clk)
    begin
        ta_reg  <= ta_next;
        tb_reg  <= tb_next;
        n_a_reg <= n_reg;
        t_reg   <= t_next;
        n_b_reg <= n_a_reg;
    end

    // e^t as a taylor sum
    logic [F:0]    ex_term_w [NT+1];
    logic [F-1:0]  ex_t_w    [NT+1];
    logic [F+1:0]  ex_sum_w  [NT+1];
    logic [IW-1:0] ex_n_w    [NT+1];

    assign ex_term_w[0] = {1'b1, {F{1'b0}}};
    assign ex_t_w[0]    = t_reg;
    assign ex_sum_w[0]  = {2'b01, {F{1'b0}}};
    assign ex_n_w[0]    = n_b_reg;

    for (genvar i = 0; i < NT; i++)
    begin : g_exp
        bpa_exp_cell #(
            .FRAC_BITS (F),
            .TERM_K    (i + 1),
            .TAG_W     (IW)
        ) u_exp_cell (
            .clk      (clk),
            .term_in  (ex_term_w[i]),
            .t_in     (ex_t_w[i]),
            .sum_in   (ex_sum_w[i]),
            .tag_in   (ex_n_w[i]),
            .term_out (ex_term_w[i+1]),
            .t_out    (ex_t_w[i+1]),
            .sum_out  (ex_sum_w[i+1]),
            .tag_out  (ex_n_w[i+1])
        );
    end

    // power term, then the altitude difference
    logic [IW-1:0]  n_e;
    logic [IW-1:0]  n_neg;
    logic [PWW-1:0] pw_next;
    logic [PWW-1:0] pw_reg;
    logic           dir_next;
    logic [PWW-1:0] d_next;
    logic           dir_reg;
    logic [PWW-1:0] d_reg;
    logic [KPW-1:0] k_prod;
    logic [M_W-1:0] m_next;
    logic           st_next;
    logic [M_W-1:0] m_reg;
    logic           st_reg;
    logic           dir2_reg;
    logic [QPW-1:0] q_prod;
    logic [Q_W-1:0] q13_next;
    logic [Q_W-1:0] q13_reg;
    logic [M_W-1:0] m2_reg;
    logic           st2_reg;
    logic           dir3_reg;

    assign n_e   = ex_n_w[NT];
    assign n_neg = ~n_e + IW'(1);

    always_comb
    begin
        if (sb_reg[EXP_END].zero)
        begin
            pw_next = '0;
        end
        else if (!n_e[IW-1])
        begin
            pw_next = PWW'(ex_sum_w[NT]) << n_e[1:0];
        end
        else
        begin
            pw_next = PWW'(ex_sum_w[NT]) >> n_neg;
        end
    end

    assign dir_next = pw_reg > ONE_Q;
    assign d_next   = dir_next ? (pw_reg - ONE_Q) : (ONE_Q - pw_reg);
    assign k_prod   = KPW'(d_reg) * KPW'(k_reg);
    assign m_next   = k_prod[F +: M_W];
    assign st_next  = |k_prod[F-1:0];
    assign q_prod   = QPW'(m_reg) * QPW'(bpa_pkg::R13);
    assign q13_next = q_prod[bpa_pkg::R13_SH +: Q_W];

    always_ff @(posedge clk)
    begin
        pw_reg   <= pw_next;
        dir_reg  <= dir_next;
        d_reg    <= d_next;
        m_reg    <= m_next;
        st_reg   <= st_next;
        dir2_reg <= dir_reg;
        q13_reg  <= q13_next;
        m2_reg   <= m_reg;
        st2_reg  <= st_reg;
        dir3_reg <= dir2_reg;
    end

    // add to or subtract from the reference altitude, then clamp
    logic [M_W-1:0]        q_times13;
    logic                  rem_nz;
    logic signed [A_W-1:0] aref_ext;
    logic signed [A_W-1:0] q_ext;
    logic signed [A_W-1:0] a_sub;
    logic                  adj;
    logic signed [A_W-1:0] a_next;
    logic signed [A_W-1:0] a_reg;
    logic [ALT_W-1:0]      alt_next;
    logic                  sat_next;
    logic [ALT_W-1:0]      alt_reg;
    logic                  sat_reg;

    assign q_times13 = (M_W'(q13_reg) << 3) + (M_W'(q13_reg) << 2) + M_W'(q13_reg);
    assign rem_nz    = m2_reg != q_times13;
    assign aref_ext  = A_W'(ref_alt_reg);
    assign q_ext     = A_W'(q13_reg);
    assign a_sub     = aref_ext - q_ext;
    assign adj       = (a_sub > 0) && (st2_reg || rem_nz);
    assign a_next    = dir3_reg ? (a_sub - A_W'(adj)) : (aref_ext + q_ext);

    always_comb
    begin
        if (a_reg > A_HI)
        begin
            alt_next = A_HI[ALT_W-1:0];
            sat_next = 1'b1;
        end
        else if (a_reg < A_LO)
        begin
            alt_next = A_LO[ALT_W-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            alt_next = a_reg[ALT_W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        alt_reg <= alt_next;
        sat_reg <= sat_next;
    end

    assign done        = sb_reg[OUT_COL].valid;
    assign altitude_dm = alt_reg;
    assign saturated   = sat_reg;

endmodule

// ----- sv/bpa_checker.sv -----
// port-level checks of the barometric altitude unit, bound to the top level
`timescale 1ns / 1ps
`include "barometric_pressure_to_altitude_unit_defines.svh"

module bpa_port_checker #(
    parameter int FRAC_BITS = 28
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic signed [bpa_pkg::ALT_W-1:0] altitude_dm,
    input logic                             saturated,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    localparam int NW  = FRAC_BITS + bpa_pkg::P_W;
    localparam int LAT = 2 * FRAC_BITS + $clog2(NW) + 124;

    `BPA_ASSERT_PAST(a_done_after_request, done, start && !busy, LAT, "done without request")
    `BPA_ASSERT_NOW(a_sat_at_bound, done && saturated, (altitude_dm == bpa_pkg::ALT_MAX) || (altitude_dm == bpa_pkg::ALT_MIN), "saturated value off bound")
    `BPA_ASSERT_NOW(a_alt_range, done, (altitude_dm <= bpa_pkg::ALT_MAX) && (altitude_dm >= bpa_pkg::ALT_MIN), "altitude out of range")
    `BPA_ASSERT_NOW(a_always_open, start || cfg_valid, !busy && cfg_ready, "request refused")

endmodule

bind barometric_pressure_to_altitude_unit bpa_port_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_bpa_checker (.*);
